// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- hdl/mmps_pkg.sv -----
// ----------------------------------------------------------------------------
// Masked pattern search package
// Word types, configuration register codes and sizes shared by the search
// cells, the output buffer and the top level.
// ----------------------------------------------------------------------------
package mmps_pkg;

    localparam int NUM_SLOTS   = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int POS_W       = 63;
    localparam int COUNT_W     = 61;
    localparam int LEN_W       = 4;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_P0_VALUE  = 3'd0,
        REG_P0_MASK   = 3'd1,
        REG_P0_LENGTH = 3'd2,
        REG_P1_VALUE  = 3'd3,
        REG_P1_MASK   = 3'd4,
        REG_P1_LENGTH = 3'd5,
        REG_BASE_POS  = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] match_position;
        logic             matched_slot;
    } out_word_t;

    typedef struct packed {
        logic [63:0]      value;
        logic [63:0]      mask;
        logic [LEN_W-1:0] length;
    } slot_cfg_t;

    typedef struct packed {
        logic advance;
        logic restart;
    } cell_ctl_t;

endpackage

// ----- hdl/mmps_cell.sv -----
// ----------------------------------------------------------------------------
// Search cell
// Holds one byte of the history window, hands it to the next cell on every
// advancing byte and compares the incoming byte with its aligned pattern byte.
// ----------------------------------------------------------------------------
module mmps_cell #(
    parameter int IDX = 0
) (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  mmps_pkg::cell_ctl_t                              ctl,
    input  mmps_pkg::slot_cfg_t [mmps_pkg::NUM_SLOTS-1:0]    slots,
    input  logic [7:0]                                       byte_in,
    input  logic                                             valid_in,
    output logic [7:0]                                       byte_out,
    output logic                                             valid_out,
    output logic [mmps_pkg::NUM_SLOTS-1:0]                   hit
);
    import mmps_pkg::*;

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       valid_reg;
    logic       valid_next;
    logic       vin;

    // restart empties every cell but the entry one
    assign vin = valid_in && (!ctl.restart || (IDX == 0));

    assign byte_next  = ctl.advance ? byte_in : byte_reg;
    assign valid_next = ctl.advance ? vin : valid_reg;

    always_comb
    begin
        logic [LEN_W-1:0] len;
        logic [LEN_W-1:0] k;
        logic [5:0]       sel;
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            len = slots[s].length;
            k   = len - LEN_W'(IDX) - LEN_W'(1);
            sel = {k[2:0], 3'b000};
            if (len > LEN_W'(IDX))
            begin
                hit[s] = vin &&
                    ((byte_in & slots[s].mask[sel +: 8]) == slots[s].value[sel +: 8]);
            end
            else
            begin
                hit[s] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_out  = byte_reg;
    assign valid_out = valid_reg;

endmodule

// ----- hdl/mmps_out_buf.sv -----
// ----------------------------------------------------------------------------
// Result output buffer
// Output register plus one skid entry, so a new word can be taken while a
// finished result waits for the receiver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mmps_out_buf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mmps_pkg::out_word_t push_data,
    output logic                full,
    output logic                out_valid,
    input  logic                out_stall,
    output mmps_pkg::out_word_t out_data
);
    import mmps_pkg::*;

    logic      main_valid_reg;
    logic      main_valid_next;
    out_word_t main_reg;
    out_word_t main_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    out_word_t skid_reg;
    out_word_t skid_next;
    logic      pop;

    assign pop = main_valid_reg && !out_stall;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_next       = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    `ASSERT_ALWAYS(a_skid_behind_main, clk, rst_n, !skid_valid_reg || main_valid_reg,
        "skid entry holds a word while the output register is empty")
    `ASSERT_IMPL(a_no_push_when_full, clk, rst_n, push, !skid_valid_reg,
        "word pushed into a full output buffer")

endmodule

// ----- hdl/masked_multi_pattern_search_top.sv -----
// ----------------------------------------------------------------------------
// Masked multi-pattern search, top level
// Takes one stream byte per cycle unless stalled. Each accepted byte shifts
// into a row of MAX_PATTERN_BYTES cells; every cell compares the byte it
// receives against its masked pattern byte for both slots in the same cycle,
// so the hit, the slot and the bit position (base plus eight times the byte
// offset) are settled at the accepting edge and the result word is registered
// in the output buffer. A two-entry output buffer keeps input flowing
// while the receiver stalls; input stalls only when both entries are full.
// After a match or a last byte, bytes are dropped without result until a
// byte with first set. Configuration registers take effect on the next byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module masked_multi_pattern_search_top #(
    parameter int MAX_PATTERN_BYTES = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [mmps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mmps_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  mmps_pkg::in_word_t                   in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output mmps_pkg::out_word_t                  out_data
);
    import mmps_pkg::*;

    slot_cfg_t [NUM_SLOTS-1:0] slots_reg;
    logic [POS_W-1:0]          base_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        count_next;
    logic                      done_reg;
    logic                      done_next;

    logic                      accept;
    logic                      adv;
    cell_ctl_t                 ctl;
    logic [7:0]                cell_byte [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0] cell_valid;
    logic [NUM_SLOTS-1:0]      cell_hit [MAX_PATTERN_BYTES];
    logic [NUM_SLOTS-1:0]      slot_hit;
    logic                      hit_any;

    logic [COUNT_W-1:0]        count_base;
    logic                      count_sat;
    logic [COUNT_W-1:0]        count_inc;
    logic [LEN_W-1:0]          win_len;
    logic [LEN_W-1:0]          adj;
    logic [COUNT_W-1:0]        offset;
    logic [POS_W-1:0]          position;

    logic                      push;
    out_word_t                 push_data;
    logic                      buf_full;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= '0;
            base_reg  <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_P0_VALUE:  slots_reg[0].value  <= cfg_data;
                REG_P0_MASK:   slots_reg[0].mask   <= cfg_data;
                REG_P0_LENGTH: slots_reg[0].length <= cfg_data[LEN_W-1:0];
                REG_P1_VALUE:  slots_reg[1].value  <= cfg_data;
                REG_P1_MASK:   slots_reg[1].mask   <= cfg_data;
                REG_P1_LENGTH: slots_reg[1].length <= cfg_data[LEN_W-1:0];
                REG_BASE_POS:  base_reg            <= cfg_data[POS_W-1:0];
                default:       ;
            endcase
        end
    end

    assign accept      = in_valid && !in_stall;
    assign adv         = accept && (in_data.first || !done_reg);
    assign ctl.advance = adv;
    assign ctl.restart = in_data.first;

    // cell row
    for (genvar j = 0; j < MAX_PATTERN_BYTES; j++)
    begin : g_cell
        logic [7:0] b_in;
        logic       v_in;
        if (j == 0)
        begin : g_head
            assign b_in = in_data.data_byte;
            assign v_in = 1'b1;
        end
        else
        begin : g_body
            assign b_in = cell_byte[j-1];
            assign v_in = cell_valid[j-1];
        end
        mmps_cell #(
            .IDX (j)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .slots     (slots_reg),
            .byte_in   (b_in),
            .valid_in  (v_in),
            .byte_out  (cell_byte[j]),
            .valid_out (cell_valid[j]),
            .hit       (cell_hit[j])
        );
    end

    always_comb
    begin
        for (int s = 0; s < NUM_SLOTS; s++)
        begin
            slot_hit[s] = (slots_reg[s].length != '0) &&
                (slots_reg[s].length <= LEN_W'(MAX_PATTERN_BYTES));
            for (int j = 0; j < MAX_PATTERN_BYTES; j++)
            begin
                slot_hit[s] = slot_hit[s] && cell_hit[j][s];
            end
        end
    end

    assign hit_any = |slot_hit;

    // byte count and match position
    assign count_base = in_data.first ? '0 : count_reg;
    assign count_sat  = (count_base == COUNT_MAX);
    assign count_inc  = count_sat ? count_base : count_base + COUNT_W'(1);
    assign count_next = adv ? count_inc : count_reg;

    assign win_len  = slot_hit[0] ? slots_reg[0].length : slots_reg[1].length;
    assign adj      = count_sat ? win_len : win_len - LEN_W'(1);
    assign offset   = count_base - COUNT_W'(adj);
    assign position = base_reg + {offset[POS_W-4:0], 3'b000};

    assign done_next = adv ? (hit_any || in_data.last) : done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // result word
    assign push                     = adv && (hit_any || in_data.last);
    assign push_data.found          = hit_any;
    assign push_data.match_position = hit_any ? position : '0;
    assign push_data.matched_slot   = !slot_hit[0] && slot_hit[1];

    mmps_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign in_stall = buf_full;

    `ASSERT_NEXT(a_result_ends_search, clk, rst_n, push, done_reg,
        "search still open after a result word")
    `ASSERT_ALWAYS(a_count_tracks_head, clk, rst_n, (count_reg != '0) == cell_valid[0],
        "byte count and head cell disagree")
    `ASSERT_IMPL(a_hit_needs_bytes, clk, rst_n, adv && slot_hit[0],
        count_next >= COUNT_W'(slots_reg[0].length),
        "slot 0 hit with fewer bytes than its length")

endmodule
